// ----- hw/rtl/ptt_pkg.sv -----
// shared types and constants for the periodic timer table
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

	localparam int DEPTH_DEFAULT = 16;

	// operation codes carried on the input tuser
	typedef enum logic [2:0] {
		FN_TICK   = 3'd0,
		FN_ADD    = 3'd1,
		FN_CLEAR  = 3'd2,
		FN_PAUSE  = 3'd3,
		FN_RESUME = 3'd4,
		FN_CHANGE = 3'd5,
		FN_QUERY  = 3'd6
	} func_t;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOID   = 2'd1;
	localparam logic [1:0] ST_PERIOD = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// one timer entry as stored in the table memory
	typedef struct packed {
		logic [15:0] ident;
		logic [14:0] limit;
		logic [14:0] count;
		logic        paused;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] new_id;
		logic        counter_zero;
		logic        fired_valid;
		logic [15:0] fired_id;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ptt_entry_ram.sv -----
// timer entry memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module ptt_entry_ram
	import ptt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [IW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic [IW-1:0] rd_addr,
	output entry_t             rd_data
);

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/periodic_timer_table_core.sv -----
// top level of the periodic timer table
//
// Up to DEPTH periodic timers live in one synchronous memory, compact in
// insertion order. One operation is processed at a time. Add, and an
// undefined operation, go straight to the emit state. A tick walks the used
// entries, each with a memory read, then update and write back. Each fired
// timer other than the last one is emitted as its own result, and the walk
// waits while the output side stalls a fired result. Clear, pause, resume,
// change and query scan for the ID with a read then a compare per entry;
// clear then shifts the later entries down through the same memory port.
// The memory needs no clearing after reset, as only entries below the used
// count are read.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_table_core
	import ptt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // timer_id[15:0], period_ticks[31:16]
	input  wire logic [2:0]  s_axis_tuser,  // func[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // status[1:0], new_id[17:2],
	                                        // counter_zero[18], fired_id[34:19], zeros
	output logic [0:0]       m_axis_tuser,  // fired_valid[0]
	output logic             m_axis_tlast
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADV,
		S_EV,
		S_SH_ADV,
		S_SH_EV,
		S_EMIT
	} state_t;

	state_t      state_q, ret_q;
	func_t       func_q;
	logic [15:0] id_q;
	logic [15:0] per_q;
	logic [CW-1:0] used_q, idx_q;
	logic [15:0] next_id_q;
	logic        pend_q;
	logic [15:0] pend_id_q;
	result_t     res_q, out_q;
	logic        out_valid_q;

	entry_t        rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;

	logic        accept, out_free, pbad_in, pbad_q, full, fire;
	func_t       func_in;
	logic [15:0] in_id, in_per;
	logic [CW-1:0] idx_inc, idx_dec;

	// single result with last set
	function automatic result_t done_result(input logic [1:0] st);
		result_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	// result of a lookup operation that found its entry
	function automatic result_t found_result(input func_t fn, input logic bad,
			input logic zero);
		result_t r;
		r = '0;
		r.last = 1'b1;
		if (fn == FN_CHANGE && bad) begin
			r.status = ST_PERIOD;
		end
		if (fn == FN_QUERY) begin
			r.counter_zero = zero;
		end
		return r;
	endfunction

	assign func_in  = func_t'(s_axis_tuser);
	assign in_id    = s_axis_tdata[15:0];
	assign in_per   = s_axis_tdata[31:16];
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign pbad_in  = (in_per == 16'd0) || in_per[15];
	assign pbad_q   = (per_q == 16'd0) || per_q[15];
	assign full     = (used_q == CW'(DEPTH));
	assign idx_inc  = idx_q + CW'(1);
	assign idx_dec  = idx_q - CW'(1);
	assign fire     = (rd_data.count == rd_data.limit);

	// output port packing
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_q.fired_id, out_q.counter_zero,
	                        out_q.new_id, out_q.status};
	assign m_axis_tuser  = out_q.fired_valid;
	assign m_axis_tlast  = out_q.last;

	ptt_entry_ram #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (rd_data)
	);

	// memory write selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_IDLE: begin
				wr_addr = used_q[IW-1:0];
				wr_data = '{ident: next_id_q, limit: in_per[14:0], count: '0, paused: 1'b0};
				wr_en   = accept && (func_in == FN_ADD) && !pbad_in && !full;
			end
			S_EV: begin
				if (func_q == FN_TICK) begin
					wr_en         = !rd_data.paused;
					wr_data.count = (fire ? 15'd0 : rd_data.count) + 15'd1;
				end else if (rd_data.ident == id_q) begin
					if (func_q == FN_PAUSE || func_q == FN_RESUME) begin
						wr_en          = 1'b1;
						wr_data.paused = (func_q == FN_PAUSE);
					end else if (func_q == FN_CHANGE && !pbad_q) begin
						wr_en         = 1'b1;
						wr_data.limit = per_q[14:0];
						wr_data.count = '0;
					end
				end
			end
			S_SH_EV: begin
				wr_en   = 1'b1;
				wr_addr = idx_dec[IW-1:0];
			end
			default: begin
			end
		endcase
	end

	// sequencer, table counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			func_q      <= FN_TICK;
			id_q        <= '0;
			per_q       <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			next_id_q   <= 16'd1;
			pend_q      <= 1'b0;
			pend_id_q   <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register loads from the emit state, drains on a transaction
			if (state_q == S_EMIT && out_free) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= func_in;
						id_q   <= in_id;
						per_q  <= in_per;
						idx_q  <= '0;
						pend_q <= 1'b0;
						ret_q  <= S_IDLE;
						unique case (func_in)
							FN_TICK, FN_CLEAR, FN_PAUSE, FN_RESUME, FN_CHANGE,
							FN_QUERY: begin
								state_q <= S_ADV;
							end
							FN_ADD: begin
								state_q <= S_EMIT;
								if (pbad_in) begin
									res_q <= done_result(ST_PERIOD);
								end else if (full) begin
									res_q <= done_result(ST_FULL);
								end else begin
									res_q <= '{status: ST_OK, new_id: next_id_q,
									          counter_zero: 1'b0, fired_valid: 1'b0,
									          fired_id: 16'd0, last: 1'b1};
									used_q    <= used_q + CW'(1);
									next_id_q <= next_id_q + 16'd1;
								end
							end
							default: begin
								state_q <= S_EMIT;
								res_q   <= done_result(ST_OK);
							end
						endcase
					end
				end
				S_ADV: begin
					// end of the walk, or read issued for idx_q
					if (idx_q == used_q) begin
						ret_q   <= S_IDLE;
						state_q <= S_EMIT;
						if (func_q == FN_TICK) begin
							res_q <= '{status: ST_OK, new_id: 16'd0, counter_zero: 1'b0,
							          fired_valid: pend_q,
							          fired_id: pend_q ? pend_id_q : 16'd0, last: 1'b1};
						end else begin
							res_q <= done_result(ST_NOID);
						end
					end else begin
						state_q <= S_EV;
					end
				end
				S_EV: begin
					if (func_q == FN_TICK) begin
						idx_q <= idx_inc;
						if (!rd_data.paused && fire) begin
							pend_q    <= 1'b1;
							pend_id_q <= rd_data.ident;
						end
						// an earlier fired timer is not the last one
						if (!rd_data.paused && fire && pend_q) begin
							res_q   <= '{status: ST_OK, new_id: 16'd0, counter_zero: 1'b0,
							            fired_valid: 1'b1, fired_id: pend_id_q, last: 1'b0};
							ret_q   <= S_ADV;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_ADV;
						end
					end else if (rd_data.ident == id_q) begin
						ret_q <= S_IDLE;
						if (func_q == FN_CLEAR) begin
							res_q   <= done_result(ST_OK);
							idx_q   <= idx_inc;
							state_q <= S_SH_ADV;
						end else begin
							res_q   <= found_result(func_q, pbad_q, rd_data.count == 15'd0);
							state_q <= S_EMIT;
						end
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_ADV;
					end
				end
				S_SH_ADV: begin
					// shift later entries down one place
					if (idx_q == used_q) begin
						used_q  <= used_q - CW'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SH_EV;
					end
				end
				S_SH_EV: begin
					idx_q   <= idx_inc;
					state_q <= S_SH_ADV;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the periodic timer table core
`timescale 1ns / 1ps
`default_nettype none
module testbench
	import ptt_pkg::*;
;

	localparam int DEPTH = 16;
	localparam logic [2:0] FN_UNDEF = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;

	periodic_timer_table_core #(.DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// shadow copy of the timer table
	logic [15:0] tbl_ident [DEPTH];
	logic [14:0] tbl_limit [DEPTH];
	logic [14:0] tbl_count [DEPTH];
	logic        tbl_paused [DEPTH];
	int          tbl_used;
	logic [15:0] tbl_next_id;

	result_t expected_results [$];
	int      error_count;
	int      burst_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("testbench: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int find_timer(input logic [15:0] id);
		for (int i = 0; i < tbl_used; i++)
			if (tbl_ident[i] == id) return i;
		return -1;
	endfunction

	function automatic result_t make_result(input logic [1:0] st);
		result_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	// predict the results of one operation and update the shadow table
	task automatic predict_timer_op(input logic [2:0] fn, input logic [15:0] id,
			input logic [15:0] period);
		result_t r;
		int idx;
		int fired;
		logic bad;
		bad = (period == 16'd0) || period[15];
		idx = find_timer(id);
		r = make_result(ST_OK);
		case (fn)
			FN_TICK: begin
				fired = 0;
				for (int i = 0; i < tbl_used; i++) begin
					if (!tbl_paused[i]) begin
						if (tbl_count[i] == tbl_limit[i]) begin
							tbl_count[i] = '0;
							r = '0;
							r.fired_valid = 1'b1;
							r.fired_id = tbl_ident[i];
							expected_results.push_back(r);
							fired++;
						end
						tbl_count[i] = tbl_count[i] + 15'd1;
					end
				end
				if (fired == 0) expected_results.push_back(make_result(ST_OK));
				else expected_results[$].last = 1'b1;
				return;
			end
			FN_ADD: begin
				if (bad) r.status = ST_PERIOD;
				else if (tbl_used >= DEPTH) r.status = ST_FULL;
				else begin
					tbl_ident[tbl_used] = tbl_next_id;
					tbl_limit[tbl_used] = period[14:0];
					tbl_count[tbl_used] = '0;
					tbl_paused[tbl_used] = 1'b0;
					tbl_used++;
					r.new_id = tbl_next_id;
					tbl_next_id = tbl_next_id + 16'd1;
				end
			end
			FN_CLEAR: begin
				if (idx < 0) r.status = ST_NOID;
				else begin
					for (int i = idx; i + 1 < tbl_used; i++) begin
						tbl_ident[i] = tbl_ident[i+1];
						tbl_limit[i] = tbl_limit[i+1];
						tbl_count[i] = tbl_count[i+1];
						tbl_paused[i] = tbl_paused[i+1];
					end
					tbl_used--;
				end
			end
			FN_PAUSE, FN_RESUME: begin
				if (idx < 0) r.status = ST_NOID;
				else tbl_paused[idx] = (fn == FN_PAUSE);
			end
			FN_CHANGE: begin
				if (idx < 0) r.status = ST_NOID;
				else if (bad) r.status = ST_PERIOD;
				else begin
					tbl_limit[idx] = period[14:0];
					tbl_count[idx] = '0;
				end
			end
			FN_QUERY: begin
				if (idx < 0) r.status = ST_NOID;
				else r.counter_zero = (tbl_count[idx] == '0);
			end
			default: ;
		endcase
		expected_results.push_back(r);
	endtask

	// send one transaction, with bursts and gaps on the input side
	task automatic send_op(input logic [2:0] fn, input logic [15:0] id,
			input logic [15:0] period);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {period, id};
		predict_timer_op(fn, id, period);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// output stall pattern: long ready runs mixed with stall runs
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			m_axis_tready <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[1:0] != want.status)
					report_mismatch("status", 16'(m_axis_tdata[1:0]), 16'(want.status));
				if (m_axis_tdata[17:2] != want.new_id)
					report_mismatch("new_id", m_axis_tdata[17:2], want.new_id);
				if (m_axis_tdata[18] != want.counter_zero)
					report_mismatch("counter_zero", 16'(m_axis_tdata[18]),
						16'(want.counter_zero));
				if (m_axis_tdata[34:19] != want.fired_id)
					report_mismatch("fired_id", m_axis_tdata[34:19], want.fired_id);
				if (m_axis_tdata[39:35] != 5'd0)
					report_mismatch("pad", 16'(m_axis_tdata[39:35]), 16'd0);
				if (m_axis_tuser[0] != want.fired_valid)
					report_mismatch("fired_valid", 16'(m_axis_tuser[0]),
						16'(want.fired_valid));
				if (m_axis_tlast != want.last)
					report_mismatch("last", 16'(m_axis_tlast), 16'(want.last));
			end
		end
	end

	function automatic logic [15:0] pick_id();
		if (tbl_used > 0 && $urandom_range(0, 9) < 8)
			return tbl_ident[$urandom_range(0, tbl_used - 1)];
		return 16'($urandom());
	endfunction

	function automatic logic [15:0] pick_period();
		case ($urandom_range(0, 9))
			0: return 16'($urandom());
			1: return 16'd0;
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	// every operation and its error paths but the full table, plus the field extremes
	task automatic test_directed();
		send_op(FN_TICK, 16'h0000, 16'h0000);
		send_op(FN_ADD, 16'hFFFF, 16'h0000);
		send_op(FN_ADD, 16'h0000, 16'h8000);
		send_op(FN_ADD, 16'h0000, 16'hFFFF);
		send_op(FN_ADD, 16'hFFFF, 16'h0001);
		send_op(FN_ADD, 16'h0000, 16'h7FFF);
		send_op(FN_ADD, 16'h0000, 16'h0002);
		send_op(FN_QUERY, 16'd1, 16'h0000);
		send_op(FN_TICK, 16'hFFFF, 16'hFFFF);
		send_op(FN_QUERY, 16'd1, 16'h0000);
		send_op(FN_TICK, 16'h0000, 16'h0000);
		send_op(FN_TICK, 16'h0000, 16'h0000);
		send_op(FN_PAUSE, 16'd2, 16'h0000);
		send_op(FN_TICK, 16'h0000, 16'h0000);
		send_op(FN_RESUME, 16'd2, 16'h0000);
		send_op(FN_CHANGE, 16'd3, 16'hFFFF);
		send_op(FN_CHANGE, 16'd3, 16'h0001);
		send_op(FN_CHANGE, 16'hFFFF, 16'h0001);
		send_op(FN_QUERY, 16'hFFFF, 16'h0000);
		send_op(FN_PAUSE, 16'hFFFF, 16'h0000);
		send_op(FN_RESUME, 16'hFFFF, 16'h0000);
		send_op(FN_CLEAR, 16'd2, 16'h0000);
		send_op(FN_CLEAR, 16'd2, 16'h0000);
		send_op(FN_UNDEF, 16'hFFFF, 16'hFFFF);
	endtask

	// fill to full, overflow, then clear down to four entries
	task automatic test_full_table();
		while (tbl_used < DEPTH) send_op(FN_ADD, 16'($urandom()), 16'd1);
		send_op(FN_ADD, 16'h0000, 16'd3);
		send_op(FN_ADD, 16'h0000, 16'h0000);
		send_op(FN_TICK, 16'h0000, 16'h0000);
		send_op(FN_TICK, 16'h0000, 16'h0000);
		send_op(FN_CLEAR, tbl_ident[0], 16'h0000);
		send_op(FN_CLEAR, tbl_ident[tbl_used - 1], 16'h0000);
		while (tbl_used > 4)
			send_op(FN_CLEAR, tbl_ident[$urandom_range(0, tbl_used - 1)], 16'h0);
	endtask

	// random mix, weighted toward ticks and valid ids
	task automatic test_random_ops(input int count);
		logic [2:0] fn;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: fn = FN_TICK;
				6, 7, 8: fn = (tbl_used < DEPTH - 2) ? FN_ADD : FN_CLEAR;
				9, 10: fn = FN_CLEAR;
				11, 12: fn = FN_PAUSE;
				13, 14: fn = FN_RESUME;
				15, 16: fn = FN_CHANGE;
				17, 18: fn = FN_QUERY;
				default: fn = 3'($urandom_range(0, 7));
			endcase
			send_op(fn, pick_id(), pick_period());
		end
	endtask

	initial begin
		int wait_cycles;
		error_count = 0;
		burst_left = 0;
		tbl_used = 0;
		tbl_next_id = 16'd1;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_ident[i] = '0; tbl_limit[i] = '0; tbl_count[i] = '0; tbl_paused[i] = 1'b0;
		end
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random_ops(175);
		s_axis_tvalid <= 1'b0;
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
